// File: sv/v3ln_pkg.sv
`default_nettype none
package v3ln_pkg;
   localparam int OUT_BITS  = 32;
   localparam int ROOT_BITS = 64;
   localparam int SUM_BITS  = 128;
   localparam int UNIT_FRAC = 30;
endpackage
`default_nettype wire

// File: sv/v3ln_if.sv
`default_nettype none
interface v3ln_req_if #(parameter int COMP_BITS = 32) ();
   logic                        valid;
   logic                        ready;
   logic signed [COMP_BITS-1:0] comp_x;
   logic signed [COMP_BITS-1:0] comp_y;
   logic signed [COMP_BITS-1:0] comp_z;
   modport source (output valid, comp_x, comp_y, comp_z, input ready);
   modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface v3ln_rsp_if ();
   logic               valid;
   logic               ready;
   logic        [31:0] magnitude;
   logic signed [31:0] unit_x;
   logic signed [31:0] unit_y;
   logic signed [31:0] unit_z;
   logic               zero_vector;
   modport source (output valid, magnitude, unit_x, unit_y, unit_z, zero_vector,
                   input ready);
   modport sink   (input valid, magnitude, unit_x, unit_y, unit_z, zero_vector,
                   output ready);
endinterface
`default_nettype wire

// File: sv/vector3_length_normalize_core.sv
`default_nettype none
// Vector length and normalisation core.
// Send one vector (comp_x, comp_y, comp_z) per beat on req; each returns one
// rsp beat with the length (Q16.16, rounded down), the unit vector (Q1.30,
// truncated toward zero) and a zero_vector flag (length and units zero).
// Throughput: one beat per cycle while rsp is not stalled. Path: an item
// passes, in order, the square stage (taken at the accepting edge), the
// normalise stage, 64 square-root stages, 33 divider stages in each of
// three parallel lanes and the merge/output stage, which drives rsp.valid;
// the square root and divider set most of that depth.
// The whole pipeline moves as one: when rsp is stalled with a result
// waiting, the pipeline holds and req.ready drops; otherwise req is taken
// every cycle. Reset clears every valid bit; no item is in flight after it.
module vector3_length_normalize_core import v3ln_pkg::*; #(
   parameter int COMP_BITS = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   v3ln_req_if.sink  req,
   v3ln_rsp_if.source rsp
);
   localparam int DIV_STAGES = UNIT_FRAC + 3;
   localparam int DEPTH      = 2 + ROOT_BITS + DIV_STAGES;

   logic advance;
   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // sign split and squares
   logic [COMP_BITS-1:0] mag_in [3];
   logic                 neg_in [3];
   always_comb begin
      neg_in[0] = req.comp_x[COMP_BITS-1]; mag_in[0] = neg_in[0] ? -req.comp_x : req.comp_x;
      neg_in[1] = req.comp_y[COMP_BITS-1]; mag_in[1] = neg_in[1] ? -req.comp_y : req.comp_y;
      neg_in[2] = req.comp_z[COMP_BITS-1]; mag_in[2] = neg_in[2] ? -req.comp_z : req.comp_z;
   end

   logic [COMP_BITS-1:0]   mag_ff [3];
   logic                   neg_ff [3];
   logic [2*COMP_BITS-1:0] sq_ff  [3];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= mag_in[i];
            neg_ff[i] <= neg_in[i];
            sq_ff[i]  <= mag_in[i] * mag_in[i];
         end
      end
   end

   // sum and even normalising shift
   logic [SUM_BITS-1:0] sum_in;
   logic [6:0]          top_in;
   assign sum_in = SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
   always_comb begin
      top_in = '0;
      for (int i = 0; i < SUM_BITS; i++) if (sum_in[i]) top_in = 7'(i);
   end

   logic [SUM_BITS-1:0]  rad_ff;
   logic [6:0]           s_ff;
   logic                 zero_ff;
   logic [COMP_BITS-1:0] mag2_ff [3];
   logic                 neg2_ff [3];
   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff    <= (7'd127 - top_in) >> 1;
         rad_ff  <= sum_in << (((7'd127 - top_in) >> 1) << 1);
         zero_ff <= (sum_in == '0);
         mag2_ff <= mag_ff;
         neg2_ff <= neg_ff;
      end
   end

   logic [ROOT_BITS-1:0] root;
   v3ln_sqrt u_sqrt (.clock(clock), .advance(advance), .radicand(rad_ff), .root(root));

   // side data delayed alongside the root
   logic [6:0]           sd_ff   [1:ROOT_BITS];
   logic                 zd_ff   [1:ROOT_BITS];
   logic [COMP_BITS-1:0] md_ff   [1:ROOT_BITS][3];
   logic                 nd_ff   [1:ROOT_BITS][3];
   for (genvar k = 1; k <= ROOT_BITS; k++) begin : g_dly
      if (k == 1) begin : g_head
         always_ff @(posedge clock) begin
            if (advance) begin
               sd_ff[1] <= s_ff; zd_ff[1] <= zero_ff;
               md_ff[1] <= mag2_ff; nd_ff[1] <= neg2_ff;
            end
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (advance) begin
               sd_ff[k] <= sd_ff[k-1]; zd_ff[k] <= zd_ff[k-1];
               md_ff[k] <= md_ff[k-1]; nd_ff[k] <= nd_ff[k-1];
            end
         end
      end
   end

   // length: R >> s, saturate
   logic [ROOT_BITS-1:0] len_in;
   assign len_in = root >> sd_ff[ROOT_BITS];

   // three divider lanes
   logic signed [OUT_BITS-1:0] unit [3];
   for (genvar i = 0; i < 3; i++) begin : g_lane
      v3ln_lane #(.MAG_BITS(COMP_BITS)) u_lane (
         .clock(clock), .advance(advance), .mag(md_ff[ROOT_BITS][i]),
         .neg(nd_ff[ROOT_BITS][i]), .shift(sd_ff[ROOT_BITS]),
         .root(zd_ff[ROOT_BITS] ? ROOT_BITS'(1) : root), .unit(unit[i]));
   end

   // carry length and flag down the divider depth
   logic [OUT_BITS-1:0] ld_ff [DIV_STAGES];
   logic                fz_ff [DIV_STAGES];
   always_ff @(posedge clock) begin
      if (advance) begin
         ld_ff[0] <= (len_in > ROOT_BITS'(32'hFFFF_FFFF)) ? '1 : OUT_BITS'(len_in);
         fz_ff[0] <= zd_ff[ROOT_BITS];
         for (int k = 1; k < DIV_STAGES; k++) begin
            ld_ff[k] <= ld_ff[k-1];
            fz_ff[k] <= fz_ff[k-1];
         end
      end
   end

   // valid bits along the pipe
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;
   assign vld_in = {vld_ff[DEPTH-2:0], req.valid};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= vld_in;
   end

   // merge stage: output register
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= vld_ff[DEPTH-1];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp.magnitude   <= fz_ff[DIV_STAGES-1] ? '0 : ld_ff[DIV_STAGES-1];
         rsp.unit_x      <= fz_ff[DIV_STAGES-1] ? '0 : unit[0];
         rsp.unit_y      <= fz_ff[DIV_STAGES-1] ? '0 : unit[1];
         rsp.unit_z      <= fz_ff[DIV_STAGES-1] ? '0 : unit[2];
         rsp.zero_vector <= fz_ff[DIV_STAGES-1];
      end
   end
   assign rsp.valid = rsp_valid_ff;

   a_zero_units: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.zero_vector |-> rsp.magnitude == '0 && rsp.unit_x == '0)
      else $error("zero vector with non-zero result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.magnitude)
                                 && $stable(rsp.unit_x))
      else $error("result beat changed while stalled");
   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("request taken while stalled");
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.unit_y <= 32'sd1073741824 && rsp.unit_y >= -32'sd1073741824)
      else $error("unit component out of range");
endmodule
`default_nettype wire

// File: sv/v3ln_lane.sv
`default_nettype none
// One divider lane: restoring division, one quotient bit per stage.
module v3ln_lane import v3ln_pkg::*; #(
   parameter int MAG_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  advance,
   input  wire logic [MAG_BITS-1:0]   mag,
   input  wire logic                  neg,
   input  wire logic [6:0]            shift,
   input  wire logic [ROOT_BITS-1:0]  root,
   output logic signed [OUT_BITS-1:0] unit
);
   localparam int NUM_BITS = MAG_BITS + 63 + UNIT_FRAC;
   localparam int QB       = UNIT_FRAC + 2;
   localparam int REM_BITS = ROOT_BITS + 1;

   // numerator (mag << s) << 30; quotient stays below 2^31 since mag*2^s <= R+1
   logic [NUM_BITS-1:0] num;
   assign num = NUM_BITS'({mag, UNIT_FRAC'(0)}) << shift;

   // quotient bits above QB are zero: preload remainder with top of numerator,
   // and line the low QB numerator bits up at the top of the shifter
   logic [NUM_BITS-1:0]  num_ff  [QB+1];
   logic [REM_BITS-1:0]  rem_ff  [QB+1];
   logic [QB-1:0]        q_ff    [QB+1];
   logic [ROOT_BITS-1:0] d_ff    [QB+1];
   logic                 neg_ff  [QB+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff[0] <= num << (NUM_BITS - QB);
         rem_ff[0] <= REM_BITS'(num >> QB);
         q_ff[0]   <= '0;
         d_ff[0]   <= root;
         neg_ff[0] <= neg;
      end
   end

   // advance one quotient bit per stage
   for (genvar k = 0; k < QB; k++) begin : g_div
      logic [REM_BITS-1:0] trial_in;
      logic [REM_BITS-1:0] diff_in;
      logic                take_in;
      assign trial_in = {rem_ff[k][REM_BITS-2:0], num_ff[k][NUM_BITS-1]};
      assign take_in  = trial_in >= {1'b0, d_ff[k]};
      assign diff_in  = trial_in - {1'b0, d_ff[k]};
      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[k+1] <= num_ff[k] << 1;
            rem_ff[k+1] <= take_in ? diff_in : trial_in;
            q_ff[k+1]   <= {q_ff[k][QB-2:0], take_in};
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   logic [QB-1:0] q_sat;
   assign q_sat = (q_ff[QB] > QB'(1 << UNIT_FRAC)) ? QB'(1 << UNIT_FRAC) : q_ff[QB];
   assign unit  = neg_ff[QB] ? -OUT_BITS'(q_sat) : OUT_BITS'(q_sat);
endmodule
`default_nettype wire

// File: sv/v3ln_sqrt.sv
`default_nettype none
// Pipelined digit-by-digit square root, one root bit per stage.
module v3ln_sqrt import v3ln_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 advance,
   input  wire logic [SUM_BITS-1:0]  radicand,
   output logic      [ROOT_BITS-1:0] root
);
   localparam int REM_BITS = ROOT_BITS + 2;
   logic [SUM_BITS-1:0]  v_ff [1:ROOT_BITS];
   logic [REM_BITS-1:0]  r_ff [1:ROOT_BITS];
   logic [ROOT_BITS-1:0] q_ff [1:ROOT_BITS];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_bit
      logic [SUM_BITS-1:0]  v_cur;
      logic [REM_BITS-1:0]  r_cur;
      logic [ROOT_BITS-1:0] q_cur;
      logic [REM_BITS-1:0]  rem_in;
      logic [REM_BITS-1:0]  trial_in;
      logic                 take_in;
      // first stage starts from the radicand with an empty remainder
      if (k == 0) begin : g_head
         assign v_cur = radicand;
         assign r_cur = '0;
         assign q_cur = '0;
      end else begin : g_tail
         assign v_cur = v_ff[k];
         assign r_cur = r_ff[k];
         assign q_cur = q_ff[k];
      end
      assign rem_in   = {r_cur[REM_BITS-3:0], v_cur[SUM_BITS-1 -: 2]};
      assign trial_in = {q_cur, 2'b01};
      assign take_in  = rem_in >= trial_in;
      always_ff @(posedge clock) begin
         if (advance) begin
            v_ff[k+1] <= v_cur << 2;
            r_ff[k+1] <= take_in ? rem_in - trial_in : rem_in;
            q_ff[k+1] <= {q_cur[ROOT_BITS-2:0], take_in};
         end
      end
   end
   assign root = q_ff[ROOT_BITS];
endmodule
`default_nettype wire
